// File: hdl/assert_macros.svh
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define SPPT_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("sppt assertion failed");

`define SPPT_ASSERT_IMPL(label, clk, rst_n, pre, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (cons)) \
    else $error("sppt implication failed");

`else

`define SPPT_ASSERT(label, clk, rst_n, prop)

`define SPPT_ASSERT_IMPL(label, clk, rst_n, pre, cons)

`endif

`endif

// File: hdl/sppt_pkg.sv
package sppt_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 10;
  localparam int unsigned PatW     = 8;
  localparam int unsigned PhaseW   = 3;
  localparam int unsigned MovedW   = 4;
  localparam int unsigned AbsW     = 32;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_WIRING     = 3'd0,
    CFG_REV_LEN    = 3'd1,
    CFG_IDX_START  = 3'd2,
    CFG_IDX_END    = 3'd3,
    CFG_IDX_PAT    = 3'd4,
    CFG_INIT_PHASE = 3'd5
  } cfg_reg_e;

  typedef enum logic [2:0] {
    WIRE_STD      = 3'd0,
    WIRE_ALT_A    = 3'd1,
    WIRE_TWO_LINE = 3'd2,
    WIRE_ALT_B    = 3'd3,
    WIRE_ALT_C    = 3'd4,
    WIRE_ALT_D    = 3'd5,
    WIRE_NONE     = 3'd6
  } wiring_e;

  typedef struct packed {
    logic [PhaseW-1:0]        phase;
    logic signed [MovedW-1:0] moved;
  } phase_res_t;

endpackage

// File: hdl/sppt_phase_dec.sv
module sppt_phase_dec (
  input  logic [2:0]                   wiring_i,
  input  logic [sppt_pkg::PatW-1:0]    pattern_i,
  input  logic [sppt_pkg::PhaseW-1:0]  phase_i,
  output sppt_pkg::phase_res_t         res_o
);
  import sppt_pkg::*;

  logic [PhaseW-1:0] ns, ew, nxt;
  logic signed [MovedW-1:0] diff;

  assign ns = (phase_i == 3'd6 || phase_i == 3'd0) ? 3'd7 : 3'd3;
  assign ew = (phase_i == 3'd6 || phase_i == 3'd4) ? 3'd5 : 3'd1;

  always_comb begin
    nxt = phase_i;
    unique case (wiring_e'(wiring_i))
      WIRE_STD: begin
        unique case (pattern_i)
          8'h02: nxt = 3'd7;
          8'h06: nxt = 3'd6;
          8'h04: nxt = 3'd5;
          8'h05: nxt = 3'd4;
          8'h01: nxt = 3'd3;
          8'h09: nxt = 3'd2;
          8'h08: nxt = 3'd1;
          8'h0A: nxt = 3'd0;
          8'h03: nxt = ns;
          8'h0C: nxt = ew;
          default: nxt = phase_i;
        endcase
      end
      WIRE_ALT_A: begin
        unique case (pattern_i)
          8'h01: nxt = 3'd7;
          8'h03: nxt = 3'd6;
          8'h02: nxt = 3'd5;
          8'h06: nxt = 3'd4;
          8'h04: nxt = 3'd3;
          8'h0C: nxt = 3'd2;
          8'h08: nxt = 3'd1;
          8'h09: nxt = 3'd0;
          8'h05: nxt = ns;
          8'h0A: nxt = ew;
          default: nxt = phase_i;
        endcase
      end
      WIRE_TWO_LINE: begin
        unique case (pattern_i)
          8'h02: nxt = 3'd6;
          8'h03: nxt = 3'd4;
          8'h01: nxt = 3'd2;
          8'h00: nxt = 3'd0;
          default: nxt = phase_i;
        endcase
      end
      WIRE_ALT_B: begin
        unique case (pattern_i)
          8'h08: nxt = 3'd7;
          8'h0C: nxt = 3'd6;
          8'h04: nxt = 3'd5;
          8'h06: nxt = 3'd4;
          8'h02: nxt = 3'd3;
          8'h03: nxt = 3'd2;
          8'h01: nxt = 3'd1;
          8'h09: nxt = 3'd0;
          8'h0A: nxt = ns;
          8'h07: nxt = ew;
          default: nxt = phase_i;
        endcase
      end
      WIRE_ALT_C: begin
        unique case (pattern_i)
          8'h02: nxt = 3'd7;
          8'h03: nxt = 3'd6;
          8'h01: nxt = 3'd5;
          8'h09: nxt = 3'd4;
          8'h08: nxt = 3'd3;
          8'h0C: nxt = 3'd2;
          8'h04: nxt = 3'd1;
          8'h06: nxt = 3'd0;
          default: nxt = phase_i;
        endcase
      end
      WIRE_ALT_D: begin
        unique case (pattern_i)
          8'h08: nxt = 3'd7;
          8'h0C: nxt = 3'd6;
          8'h04: nxt = 3'd5;
          8'h05: nxt = 3'd4;
          8'h01: nxt = 3'd3;
          8'h03: nxt = 3'd2;
          8'h02: nxt = 3'd1;
          8'h0A: nxt = 3'd0;
          8'h09: nxt = ns;
          8'h06: nxt = ew;
          default: nxt = phase_i;
        endcase
      end
      default: nxt = phase_i;
    endcase
  end

  // old minus new, folded into -4..4
  always_comb begin
    diff = $signed({1'b0, phase_i}) - $signed({1'b0, nxt});
    if (diff < -4) begin
      diff = diff + 4'sd8;
    end else if (diff > 4) begin
      diff = diff - 4'sd8;
    end
  end

  assign res_o.phase = nxt;
  assign res_o.moved = diff;

endmodule

// File: hdl/stepper_phase_position_tracker.sv
// Channel | Direction | Handshake                  | Payload
// cfg     | in        | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_wdata_i
// in      | in        | in_valid_i / in_stall_o    | coil_pattern_i
// out     | out       | out_valid_o / out_stall_i  | changed, optic, position, ...
//
// One coil pattern per cycle unless reducing or the output stalls: input register,
// then decode and position update into the result register, which offers the result.
// Writing a non-zero revolution length starts a restoring reduction of the held
// position; the input stalls while it runs.
// Reset: phase 0, positions 0, registers at their defaults. No clearing pass.
// A stalled output holds its result; one further pattern waits in the input register.
module stepper_phase_position_tracker #(
  parameter int unsigned POS_BITS = 10
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [sppt_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [sppt_pkg::CfgDataW-1:0]      cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [sppt_pkg::PatW-1:0]          coil_pattern_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               changed_o,
  output logic                               optic_o,
  output logic [POS_BITS-1:0]                position_o,
  output logic signed [sppt_pkg::AbsW-1:0]   absolute_position_o,
  output logic signed [sppt_pkg::MovedW-1:0] moved_o,
  output logic [sppt_pkg::PhaseW-1:0]        rotor_phase_o
);
  import sppt_pkg::*;
  `include "assert_macros.svh"

  localparam int unsigned CntW = $clog2(POS_BITS);

  logic [2:0]          wiring_q;
  logic [POS_BITS-1:0] max_q, istart_q, iend_q;
  logic [PatW-1:0]     ipat_q;
  logic [POS_BITS-1:0] cfg_pos;
  logic                cfg_we;

  logic                in_vld_q;
  logic [PatW-1:0]     pat_q;
  logic                process;

  logic [PhaseW-1:0]   phase_q;
  logic [POS_BITS-1:0] wpos_q, res_q, res_d;
  logic signed [AbsW-1:0] abs_q;
  phase_res_t          dec;

  logic                red_busy_q;
  logic [CntW-1:0]     red_cnt_q;
  logic [2*POS_BITS-1:0] red_div, red_ext;

  logic [POS_BITS-1:0] smod, pos;
  logic [POS_BITS:0]   sum;
  logic                inwin, patok;

  logic                out_vld_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;
  assign cfg_pos     = POS_BITS'(cfg_wdata_i);

  assign process    = in_vld_q & ~red_busy_q & (~out_vld_q | ~out_stall_i);
  assign in_stall_o = red_busy_q | (in_vld_q & ~process);

  // initial_phase only matters at reset, where it is zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wiring_q <= WIRE_STD;
      max_q    <= POS_BITS'(96);
      istart_q <= '0;
      iend_q   <= '0;
      ipat_q   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_WIRING:     wiring_q <= cfg_wdata_i[2:0];
        CFG_REV_LEN:    max_q    <= cfg_pos;
        CFG_IDX_START:  istart_q <= cfg_pos;
        CFG_IDX_END:    iend_q   <= cfg_pos;
        CFG_IDX_PAT:    ipat_q   <= cfg_wdata_i[PatW-1:0];
        CFG_INIT_PHASE: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      in_vld_q <= 1'b1;
    end else if (process) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      pat_q <= coil_pattern_i;
    end
  end

  sppt_phase_dec u_dec (
    .wiring_i  (wiring_q),
    .pattern_i (pat_q),
    .phase_i   (phase_q),
    .res_o     (dec)
  );

  // residue of the step count modulo the revolution length
  always_comb begin
    smod = '0;
    if (max_q > POS_BITS'(4)) begin
      smod = max_q + POS_BITS'(dec.moved);
      if (!dec.moved[MovedW-1]) begin
        smod = POS_BITS'(dec.moved);
      end
    end else if (max_q == POS_BITS'(4)) begin
      smod = POS_BITS'(dec.moved[1:0]);
    end else if (max_q == POS_BITS'(2)) begin
      smod = POS_BITS'(dec.moved[0]);
    end else if (max_q == POS_BITS'(3)) begin
      unique case (dec.moved)
        -4'sd4, -4'sd1, 4'sd2: smod = POS_BITS'(2);
        -4'sd2, 4'sd1, 4'sd4:  smod = POS_BITS'(1);
        default:               smod = '0;
      endcase
    end
  end

  always_comb begin
    sum = {1'b0, res_q} + {1'b0, smod};
    pos = '0;
    if (max_q != '0) begin
      pos = sum[POS_BITS-1:0];
      if (sum >= {1'b0, max_q}) begin
        pos = POS_BITS'(sum - {1'b0, max_q});
      end
    end
    if (istart_q > iend_q) begin
      inwin = (pos > istart_q) || (pos < iend_q);
    end else begin
      inwin = (pos > istart_q) && (pos < iend_q);
    end
    patok = (pat_q == ipat_q) || (ipat_q == '0);
  end

  // restoring reduction of the held position after a new revolution length
  assign red_div = {{POS_BITS{1'b0}}, max_q} << red_cnt_q;
  assign red_ext = {{POS_BITS{1'b0}}, res_q};

  always_comb begin
    res_d = res_q;
    if (red_busy_q) begin
      if (red_ext >= red_div) begin
        res_d = POS_BITS'(red_ext - red_div);
      end
    end else if (process) begin
      res_d = pos;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_busy_q <= 1'b0;
      red_cnt_q  <= '0;
    end else if (cfg_we && cfg_reg_e'(cfg_index_i) == CFG_REV_LEN && cfg_pos != '0) begin
      red_busy_q <= 1'b1;
      red_cnt_q  <= CntW'(POS_BITS - 1);
    end else if (red_busy_q) begin
      if (red_cnt_q == '0) begin
        red_busy_q <= 1'b0;
      end else begin
        red_cnt_q <= red_cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      wpos_q  <= '0;
      res_q   <= '0;
      abs_q   <= '0;
    end else begin
      res_q <= res_d;
      if (process) begin
        phase_q <= dec.phase;
        wpos_q  <= pos;
        if (max_q != '0) begin
          abs_q <= abs_q + AbsW'(dec.moved);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (process) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (process) begin
      changed_o           <= (pos != wpos_q);
      optic_o             <= inwin & patok;
      position_o          <= pos;
      absolute_position_o <= (max_q != '0) ? abs_q + AbsW'(dec.moved) : abs_q;
      moved_o             <= dec.moved;
      rotor_phase_o       <= dec.phase;
    end
  end

  assign out_valid_o = out_vld_q;

  `SPPT_ASSERT_IMPL(a_res_in_range, clk_i, rst_ni, !red_busy_q && max_q != '0, res_q < max_q)
  `SPPT_ASSERT_IMPL(a_stall_reduce, clk_i, rst_ni, red_busy_q, in_stall_o)
  `SPPT_ASSERT_IMPL(a_moved_range, clk_i, rst_ni, out_valid_o, moved_o >= -4 && moved_o <= 4)
  `SPPT_ASSERT(a_no_track, clk_i, rst_ni, (process && max_q == '0) |=> position_o == '0)

endmodule
